// ===== rtl/core/rtd_code_to_temperature_top_defines.svh =====
// assertion macros for the rtd code to temperature block
// used by rtd_code_to_temperature_top; no other dependencies
`ifndef RTD_CODE_TO_TEMPERATURE_TOP_DEFINES_SVH
`define RTD_CODE_TO_TEMPERATURE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// check gated off while reset is asserted
`define RTDCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtdct assertion failed");
// check that also holds through reset
`define RTDCT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rtdct assertion failed");
`else
`define RTDCT_ASSERT(lbl, clk, rst_n, prop)
`define RTDCT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/rtdct_pkg.sv =====
// shared types and constants for the rtd code to temperature block
// no dependencies
package rtdct_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_REFERENCE = 2'd0,
        REG_NOMINAL   = 2'd1
    } t_reg_index;

    localparam int unsigned CFG_W  = 13;
    localparam int unsigned RAW_W  = 16;
    localparam int unsigned CODE_W = 15;
    localparam int unsigned TEMP_W = 15;

    // width of the discriminant numerator and the divisor
    localparam int unsigned N_W    = 59;
    localparam int unsigned M_W    = 28;
    localparam int unsigned Q_W    = 63;
    localparam int unsigned ROOT_W = 32;

    // 1 + A*T + B*T^2 scaled to integers
    localparam logic [30:0] K_COEF   = 31'd1758480889;
    localparam logic [27:0] B_COEF   = 28'd231000000;
    localparam logic [31:0] CENTER   = 32'd2561343488;
    localparam logic [22:0] HALF_DEN = 23'd7569408;
    localparam logic [22:0] RECIP231 = 23'd4648234;
    localparam logic [21:0] POS_LIM  = 22'd3784704;
    localparam logic [21:0] NEG_LIM  = 22'd946407;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 15'sd16383;
    localparam logic [TEMP_W-1:0] TEMP_MIN = -15'sd4096;

    typedef struct packed {
        logic [CFG_W-1:0] reference_ohms;
        logic [CFG_W-1:0] nominal_ohms;
    } t_cfg;

    typedef struct packed {
        logic              out_of_range;
        logic [TEMP_W-1:0] temperature;
    } t_result;

endpackage

// ===== rtl/core/rtdct_front.sv =====
// front end: ratio code times reference, scaled discriminant numerator
// depends on rtdct_pkg
module rtdct_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rtdct_pkg::RAW_W-1:0]  i_raw,
    input  rtdct_pkg::t_cfg              i_cfg,
    output logic                         o_valid,
    output logic                         o_bad,
    output logic [rtdct_pkg::N_W-1:0]    o_num
);
    import rtdct_pkg::*;

    logic                r_v1, r_v2, r_v3;
    logic                r_nz1, r_nz2;
    logic [27:0]         r_cr;
    logic [58:0]         r_a;
    logic [55:0]         r_b;
    logic                r_bad;
    logic [N_W-1:0]      r_n;
    logic [59:0]         n_diff;

    assign n_diff = {1'b0, r_a} - {4'b0, r_b};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // code times reference, then both products, then the difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cr  <= {13'b0, i_raw[RAW_W-1:1]} * {15'b0, i_cfg.reference_ohms};
            r_nz1 <= (i_cfg.nominal_ohms == '0);
            r_a   <= {i_cfg.nominal_ohms, 15'b0, 31'b0} == '0 ? '0 :
                     59'({i_cfg.nominal_ohms, 15'b0} * K_COEF);
            r_b   <= 56'(r_cr * B_COEF);
            r_nz2 <= r_nz1;
            r_bad <= r_nz2 | n_diff[59];
            r_n   <= n_diff[N_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_bad   = r_bad;
    assign o_num   = r_n;

endmodule

// ===== rtl/core/rtdct_div.sv =====
// pipelined restoring divider: floor(num * 2^32 / (nominal << 15))
// one quotient bit per stage; depends on rtdct_pkg
module rtdct_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_bad,
    input  logic [rtdct_pkg::N_W-1:0]     i_num,
    input  logic [rtdct_pkg::CFG_W-1:0]   i_nominal,
    output logic                          o_valid,
    output logic                          o_bad,
    output logic [rtdct_pkg::Q_W-1:0]     o_quot
);
    import rtdct_pkg::*;

    localparam int unsigned LOW_W = N_W - M_W;

    logic [M_W-1:0]   w_div;
    logic             r_v   [0:Q_W-1];
    logic             r_bd  [0:Q_W-1];
    logic [M_W-1:0]   r_rem [0:Q_W-1];
    logic [LOW_W-1:0] r_low [0:Q_W-1];
    logic [Q_W-1:0]   r_q   [0:Q_W-1];

    assign w_div = {i_nominal, 15'b0};

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic             s_v, s_bd;
        logic [M_W-1:0]   s_rem;
        logic [LOW_W-1:0] s_low;
        logic [Q_W-1:0]   s_q;
        logic [M_W:0]     n_shift;
        logic             n_ge;

        if (k == 0) begin : g_first
            assign s_v   = i_valid;
            assign s_bd  = i_bad;
            assign s_rem = i_num[N_W-1:LOW_W];
            assign s_low = i_num[LOW_W-1:0];
            assign s_q   = '0;
        end else begin : g_next
            assign s_v   = r_v[k-1];
            assign s_bd  = r_bd[k-1];
            assign s_rem = r_rem[k-1];
            assign s_low = r_low[k-1];
            assign s_q   = r_q[k-1];
        end

        // shift in one dividend bit, subtract divisor when it fits
        assign n_shift = {s_rem, s_low[LOW_W-1]};
        assign n_ge    = n_shift >= {1'b0, w_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k] <= 1'b0;
            else if (i_en) r_v[k] <= s_v;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bd[k]  <= s_bd;
                r_rem[k] <= n_ge ? M_W'(n_shift - {1'b0, w_div}) : M_W'(n_shift);
                r_low[k] <= {s_low[LOW_W-2:0], 1'b0};
                r_q[k]   <= {s_q[Q_W-2:0], n_ge};
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_bad   = r_bd[Q_W-1];
    assign o_quot  = r_q[Q_W-1];

endmodule

// ===== rtl/core/rtdct_sqrt.sv =====
// pipelined integer square root, two radicand bits per stage
// depends on rtdct_pkg
module rtdct_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_bad,
    input  logic [rtdct_pkg::Q_W-1:0]     i_rad,
    output logic                          o_valid,
    output logic                          o_bad,
    output logic [rtdct_pkg::ROOT_W-1:0]  o_root
);
    import rtdct_pkg::*;

    localparam int unsigned X_W   = 2 * ROOT_W;
    localparam int unsigned REM_W = ROOT_W + 2;

    logic              r_v    [0:ROOT_W-1];
    logic              r_bd   [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [X_W-1:0]    r_x    [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              s_v, s_bd;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [X_W-1:0]    s_x;
        logic [REM_W+1:0]  n_cur, n_trial;
        logic              n_ge;

        if (k == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_bd   = i_bad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_x    = {{(X_W-Q_W){1'b0}}, i_rad};
        end else begin : g_next
            assign s_v    = r_v[k-1];
            assign s_bd   = r_bd[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_x    = r_x[k-1];
        end

        // trial subtract of 4*root + 1
        assign n_cur   = {s_rem, s_x[X_W-1:X_W-2]};
        assign n_trial = {2'b0, s_root, 2'b01};
        assign n_ge    = n_cur >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k] <= 1'b0;
            else if (i_en) r_v[k] <= s_v;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bd[k]   <= s_bd;
                r_rem[k]  <= n_ge ? REM_W'(n_cur - n_trial) : REM_W'(n_cur);
                r_root[k] <= {s_root[ROOT_W-2:0], n_ge};
                r_x[k]    <= {s_x[X_W-3:0], 2'b00};
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_bad   = r_bd[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

// ===== rtl/core/rtdct_post.sv =====
// back end: offset, scale by 20/231, round, saturate
// depends on rtdct_pkg
module rtdct_post #(
    parameter int unsigned FRACTION_BITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_bad,
    input  logic [rtdct_pkg::ROOT_W-1:0]  i_root,
    output logic                          o_valid,
    output rtdct_pkg::t_result            o_result
);
    import rtdct_pkg::*;

    localparam int unsigned MULT   = 20 << FRACTION_BITS;
    localparam int unsigned MULT_W = $clog2(MULT + 1);
    localparam int unsigned MAG_W  = ROOT_W + 1;
    localparam int unsigned NUM_W  = MAG_W + MULT_W;
    localparam int unsigned W_W    = NUM_W + 1 - 16;

    logic               r_v [0:4];
    logic               r_bd [0:3];
    logic               r_neg [0:3];
    logic [MAG_W-1:0]   r_mag;
    logic [NUM_W-1:0]   r_num;
    logic [21:0]        r_w;
    logic               r_psat, r_nsat;
    logic               r_psat2, r_nsat2;
    logic [44:0]        r_prod;
    t_result            r_res;

    logic [MAG_W:0]     n_d;
    logic [NUM_W:0]     n_sum;
    logic [W_W-1:0]     n_w;
    logic [13:0]        n_r;

    assign n_d   = {2'b0, CENTER} - {2'b0, i_root};
    assign n_sum = {1'b0, r_num} + (NUM_W+1)'(HALF_DEN);
    assign n_w   = n_sum[NUM_W:16];
    assign n_r   = r_prod[43:30];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < 5; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitude of the offset root
            r_bd[0]  <= i_bad;
            r_neg[0] <= n_d[MAG_W];
            r_mag    <= n_d[MAG_W] ? MAG_W'(-n_d) : n_d[MAG_W-1:0];
            // scale by 20 * 2^fraction_bits
            r_bd[1]  <= r_bd[0];
            r_neg[1] <= r_neg[0];
            r_num    <= NUM_W'(r_mag * MULT_W'(MULT));
            // round off the 2^16 part, check the limits
            r_bd[2]  <= r_bd[1];
            r_neg[2] <= r_neg[1];
            r_w      <= n_w[21:0];
            r_psat   <= n_w >= W_W'(POS_LIM);
            r_nsat   <= n_w >= W_W'(NEG_LIM);
            // divide by 231 through the reciprocal
            r_bd[3]  <= r_bd[2];
            r_neg[3] <= r_neg[2];
            r_prod   <= r_w * RECIP231;
            r_psat2  <= r_psat;
            r_nsat2  <= r_nsat;
            // sign and saturation
            if (r_bd[3]) begin
                r_res.temperature  <= TEMP_MAX;
                r_res.out_of_range <= 1'b1;
            end else if (r_neg[3]) begin
                r_res.temperature  <= r_nsat2 ? TEMP_MIN : TEMP_W'(-{1'b0, n_r});
                r_res.out_of_range <= r_nsat2;
            end else begin
                r_res.temperature  <= r_psat2 ? TEMP_MAX : {1'b0, n_r};
                r_res.out_of_range <= r_psat2;
            end
        end
    end

    assign o_valid  = r_v[4];
    assign o_result = r_res;

endmodule

// ===== rtl/core/rtd_code_to_temperature_top.sv =====
// RTD converter word to temperature through the inverse Callendar-Van Dusen
// quadratic. Input stream: tdata[15:0] raw word, bits 15..1 are the ratio
// code. Output stream: tdata[14:0] signed temperature in 1/16 degree units
// (2^-FRACTION_BITS in general), tuser[0] out-of-range flag.
// Config channel: index 0 reference ohms, index 1 nominal (R0) ohms, 13 bits
// each; other indexes are ignored. Write only while no words are in flight.
// Throughput one word per cycle unless the receiver stalls. Input accept to
// output valid: 3 front stages (products), 63 divider stages (one quotient
// bit each), 32 square root stages, 5 scaling stages and the output register.
// A negative discriminant or zero R0 gives +16383 with the flag set; results
// past the range clamp to 16383 or -4096 with the flag set.
// Reset (synchronous, active low) empties the pipeline and loads 400 and 100
// ohms. When the receiver stalls, one extra word is caught in a skid
// register; then the whole pipeline holds and input ready drops.
// depends on rtdct_pkg and the rtdct_* submodules
`include "rtd_code_to_temperature_top_defines.svh"
module rtd_code_to_temperature_top #(
    parameter int unsigned FRACTION_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] raw_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [14:0] temperature, [15] zero
    output logic [0:0]  o_m_tuser,   // [0] out_of_range
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import rtdct_pkg::*;

    t_cfg            r_cfg;
    logic            w_en;
    logic            f_v, f_bad;
    logic [N_W-1:0]  f_num;
    logic            d_v, d_bad;
    logic [Q_W-1:0]  d_q;
    logic            s_v, s_bad;
    logic [ROOT_W-1:0] s_root;
    logic            p_v;
    t_result         p_res;
    logic            r_out_v, r_sk_v;
    t_result         r_out, r_sk;
    logic            w_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference_ohms <= 13'd400;
            r_cfg.nominal_ohms   <= 13'd100;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REFERENCE: r_cfg.reference_ohms <= i_cfg_data;
                REG_NOMINAL:   r_cfg.nominal_ohms   <= i_cfg_data;
                default:       ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // whole pipeline moves unless the skid word is held
    assign w_en       = !r_sk_v;
    assign o_s_tready = w_en;

    rtdct_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(i_s_tvalid), .i_raw(i_s_tdata), .i_cfg(r_cfg),
        .o_valid(f_v), .o_bad(f_bad), .o_num(f_num)
    );

    rtdct_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(f_v), .i_bad(f_bad), .i_num(f_num),
        .i_nominal(r_cfg.nominal_ohms),
        .o_valid(d_v), .o_bad(d_bad), .o_quot(d_q)
    );

    rtdct_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(d_v), .i_bad(d_bad), .i_rad(d_q),
        .o_valid(s_v), .o_bad(s_bad), .o_root(s_root)
    );

    rtdct_post #(.FRACTION_BITS(FRACTION_BITS)) u_post (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(s_v), .i_bad(s_bad), .i_root(s_root),
        .o_valid(p_v), .o_result(p_res)
    );

    // output register plus skid
    assign w_take = p_v && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else begin
            if (!r_out_v || i_m_tready) begin
                if (r_sk_v) begin
                    r_out_v <= 1'b1;
                    r_sk_v  <= 1'b0;
                end else begin
                    r_out_v <= w_take;
                end
            end else if (w_take) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out <= r_sk_v ? r_sk : p_res;
        end else if (w_take) begin
            r_sk <= p_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {1'b0, r_out.temperature};
    assign o_m_tuser  = r_out.out_of_range;

    // skid only ever holds a word behind a full output register
    `RTDCT_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_sk_v |-> r_out_v)
    // skid fills only on a stalled output
    `RTDCT_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_sk_v) |-> $past(r_out_v && !i_m_tready))
    // delivered temperatures never fall below the lower clamp
    `RTDCT_ASSERT(a_temp_floor, i_clk, i_rst_n, o_m_tvalid |-> ($signed(o_m_tdata[14:0]) >= -15'sd4096))
    // reset leaves nothing on the output
    `RTDCT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule
